FILE: rtl/core/ble_pkg.sv
// ----------------------------------------------------------------------------
// ble_pkg
// Shared types and codes for the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

    // request codes
    localparam logic [2:0] REQ_APPEND  = 3'd0;
    localparam logic [2:0] REQ_FIND    = 3'd1;
    localparam logic [2:0] REQ_REM_VAL = 3'd2;
    localparam logic [2:0] REQ_REM_AT  = 3'd3;
    localparam logic [2:0] REQ_GET     = 3'd4;
    localparam logic [2:0] REQ_INSERT  = 3'd5;
    localparam logic [2:0] REQ_REVERSE = 3'd6;
    localparam logic [2:0] REQ_CLEAR   = 3'd7;

    // cell operation codes
    localparam logic [2:0] CELL_HOLD = 3'd0;
    localparam logic [2:0] CELL_ROT  = 3'd1;
    localparam logic [2:0] CELL_DEL  = 3'd2;
    localparam logic [2:0] CELL_INS  = 3'd3;
    localparam logic [2:0] CELL_APP  = 3'd4;
    localparam logic [2:0] CELL_REV  = 3'd5;

    // target index width, enough for the largest list
    localparam int CTRL_IDX_W = 12;

    typedef struct packed {
        logic [2:0]            mode;
        logic [CTRL_IDX_W-1:0] tgt;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/ble_req_if.sv
// ----------------------------------------------------------------------------
// ble_req_if
// Request channel: valid/ready with request type, position and word.
// ----------------------------------------------------------------------------
interface ble_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        req_type;
    logic signed [6:0] position;
    logic signed [31:0] value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

FILE: rtl/core/ble_rsp_if.sv
// ----------------------------------------------------------------------------
// ble_rsp_if
// Response channel: valid/ready with the result fields of one request.
// ----------------------------------------------------------------------------
interface ble_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic signed [6:0]  found_index;
    logic               ok;
    logic [6:0]         count;
    logic               empty_res;

    modport source (output valid, result_value, found_index, ok, count, empty_res,
                    input ready);
    modport sink   (input valid, result_value, found_index, ok, count, empty_res,
                    output ready);
endinterface

FILE: rtl/core/ble_cell.sv
// ----------------------------------------------------------------------------
// ble_cell
// One list slot. Holds a word and takes it from a neighbor, the incoming
// word or the head of the list as the broadcast command says.
// ----------------------------------------------------------------------------
module ble_cell #(
    parameter int W     = 32,
    parameter int INDEX = 0
) (
    input  logic                   clk,
    input  ble_pkg::cell_ctrl_t    ctrl,
    input  logic [W-1:0]           prev_word,
    input  logic [W-1:0]           next_word,
    input  logic [W-1:0]           head_word,
    input  logic [W-1:0]           wr_word,
    output logic [W-1:0]           word
);
    import ble_pkg::*;

    localparam logic [CTRL_IDX_W-1:0] MY_IDX = CTRL_IDX_W'(INDEX);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    // select the new content of this slot
    always_comb
    begin
        data_next = data_reg;
        case (ctrl.mode)
            CELL_ROT: data_next = next_word;
            CELL_DEL:
            begin
                if (MY_IDX >= ctrl.tgt) data_next = next_word;
            end
            CELL_INS:
            begin
                if (MY_IDX > ctrl.tgt)       data_next = prev_word;
                else if (MY_IDX == ctrl.tgt) data_next = wr_word;
            end
            CELL_APP:
            begin
                if (MY_IDX == ctrl.tgt) data_next = wr_word;
            end
            CELL_REV:
            begin
                if (MY_IDX < ctrl.tgt)       data_next = next_word;
                else if (MY_IDX == ctrl.tgt) data_next = head_word;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;
endmodule

FILE: rtl/core/bounded_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_list_engine
// Ordered list of signed words in a ring of cells with a request sequencer.
// ----------------------------------------------------------------------------
// Append, insert and clear run the execute and done states; find, get and removes
// add a scan that rotates the whole ring of CAPACITY cells once, and a remove that
// finds its entry adds a delete state after it; reverse adds a reverse state that
// moves one word per cycle when count >= 2. One request at a time; the next is
// taken the cycle after the response word leaves.
// Reset clears the count and the sequencer; slot contents are left as is.
module bounded_list_engine #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    ble_req_if.sink    request,
    ble_rsp_if.source  response
);
    import ble_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int SW = (CW + 1 > 8) ? CW + 1 : 8;
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DEL  = 3'd3;
    localparam logic [2:0] ST_REV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]            st_reg, st_next;
    logic [2:0]            req_reg;
    logic signed [SW-1:0]  pos_reg;
    logic [WORD_WIDTH-1:0] w_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [IW-1:0]         k_reg, k_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic                  hit_reg, hit_next;
    logic [WORD_WIDTH-1:0] res_reg, res_next;
    logic                  ok_reg, ok_next;
    logic                  fi_set_reg, fi_set_next;
    logic                  ov_reg;
    logic signed [31:0]    rv_reg;
    logic signed [6:0]     fi_reg;
    logic                  rok_reg;
    logic [6:0]            rc_reg;
    logic                  re_reg;

    cell_ctrl_t            ctrl;
    logic [WORD_WIDTH-1:0] words [CAPACITY];

    logic signed [WORD_WIDTH+31:0] vin;
    logic signed [SW-1:0]          adj_pos;
    logic                          in_rng;
    logic                          adj_rng;
    logic [IW+6:0]                 idx_ext;
    logic [CW+6:0]                 cnt_ext;
    logic signed [WORD_WIDTH+31:0] res_ext;

    // incoming word fitted to the stored width
    assign vin = (WORD_WIDTH + 32)'(request.value);

    // range checks on raw and end-relative positions
    assign adj_pos = (pos_reg < 0) ? pos_reg + $signed(SW'(cnt_reg)) : pos_reg;
    assign in_rng  = (pos_reg >= 0) && (pos_reg < $signed(SW'(cnt_reg)));
    assign adj_rng = (adj_pos >= 0) && (adj_pos < $signed(SW'(cnt_reg)));

    // ring of cells
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            ble_cell #(.W(WORD_WIDTH), .INDEX(g)) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .prev_word (words[(g == 0) ? 0 : g - 1]),
                .next_word (words[(g + 1) % CAPACITY]),
                .head_word (words[0]),
                .wr_word   (w_reg),
                .word      (words[g])
            );
        end
    endgenerate

    // sequencer
    always_comb
    begin
        st_next     = st_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        res_next    = res_reg;
        ok_next     = ok_reg;
        fi_set_next = fi_set_reg;
        ctrl.mode   = CELL_HOLD;
        ctrl.tgt    = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (request.valid && request.ready)
                begin
                    st_next     = ST_EXEC;
                    k_next      = '0;
                    hit_next    = 1'b0;
                    res_next    = '0;
                    ok_next     = 1'b0;
                    fi_set_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                st_next = ST_DONE;
                case (req_reg)
                    REQ_APPEND:
                    begin
                        if (cnt_reg < CAP_C)
                        begin
                            ctrl.mode = CELL_APP;
                            ctrl.tgt  = CTRL_IDX_W'(cnt_reg);
                            cnt_next  = cnt_reg + 1'b1;
                            ok_next   = 1'b1;
                        end
                    end
                    REQ_INSERT:
                    begin
                        if (adj_rng && cnt_reg < CAP_C)
                        begin
                            ctrl.mode = CELL_INS;
                            ctrl.tgt  = CTRL_IDX_W'(adj_pos[IW-1:0]);
                            cnt_next  = cnt_reg + 1'b1;
                            ok_next   = 1'b1;
                        end
                    end
                    REQ_REVERSE:
                    begin
                        ok_next = 1'b1;
                        idx_next = IW'(cnt_reg - 1'b1);
                        if (cnt_reg >= CW'(2)) st_next = ST_REV;
                    end
                    REQ_CLEAR:
                    begin
                        cnt_next = '0;
                        ok_next  = 1'b1;
                    end
                    REQ_FIND:
                    begin
                        fi_set_next = 1'b1;
                        st_next     = ST_SCAN;
                    end
                    REQ_GET:
                    begin
                        idx_next = adj_pos[IW-1:0];
                        hit_next = adj_rng;
                        st_next  = ST_SCAN;
                    end
                    REQ_REM_AT:
                    begin
                        idx_next = pos_reg[IW-1:0];
                        hit_next = in_rng;
                        st_next  = ST_SCAN;
                    end
                    default: st_next = ST_SCAN;
                endcase
            end
            ST_SCAN:
            begin
                // slot 0 holds entry k during this cycle
                ctrl.mode = CELL_ROT;
                k_next    = k_reg + 1'b1;
                if (req_reg == REQ_FIND || req_reg == REQ_REM_VAL)
                begin
                    if (!hit_reg && CW'(k_reg) < cnt_reg && words[0] == w_reg)
                    begin
                        hit_next = 1'b1;
                        idx_next = k_reg;
                        // find reports only the index
                        res_next = (req_reg == REQ_REM_VAL) ? words[0] : '0;
                    end
                end
                else if (hit_reg && k_reg == idx_reg)
                begin
                    res_next = words[0];
                end
                if (k_reg == LAST)
                begin
                    k_next  = '0;
                    ok_next = hit_next;
                    if ((req_reg == REQ_REM_VAL || req_reg == REQ_REM_AT) && hit_next)
                        st_next = ST_DEL;
                    else
                        st_next = ST_DONE;
                end
            end
            ST_DEL:
            begin
                ctrl.mode = CELL_DEL;
                ctrl.tgt  = CTRL_IDX_W'(idx_reg);
                cnt_next  = cnt_reg - 1'b1;
                st_next   = ST_DONE;
            end
            ST_REV:
            begin
                ctrl.mode = CELL_REV;
                ctrl.tgt  = CTRL_IDX_W'(idx_reg);
                idx_next  = idx_reg - 1'b1;
                if (idx_reg == IW'(1)) st_next = ST_DONE;
            end
            ST_DONE:
            begin
                st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // result formatting
    assign idx_ext = (IW + 7)'(idx_reg);
    assign cnt_ext = (CW + 7)'(cnt_reg);
    assign res_ext = (WORD_WIDTH + 32)'($signed(res_reg));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            if (st_reg == ST_DONE)
                ov_reg <= 1'b1;
            else if (response.ready)
                ov_reg <= 1'b0;
        end
    end

    // request and working payload
    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            req_reg <= request.req_type;
            pos_reg <= SW'(request.position);
            w_reg   <= vin[WORD_WIDTH-1:0];
        end
        k_reg      <= k_next;
        idx_reg    <= idx_next;
        hit_reg    <= hit_next;
        res_reg    <= res_next;
        ok_reg     <= ok_next;
        fi_set_reg <= fi_set_next;
        if (st_reg == ST_DONE)
        begin
            rv_reg  <= res_ext[31:0];
            fi_reg  <= (fi_set_reg && ok_reg) ? $signed(idx_ext[6:0]) : -7'sd1;
            rok_reg <= ok_reg;
            rc_reg  <= cnt_ext[6:0];
            re_reg  <= (cnt_reg == '0);
        end
    end

    assign request.ready         = (st_reg == ST_IDLE) && !ov_reg;
    assign response.valid        = ov_reg;
    assign response.result_value = rv_reg;
    assign response.found_index  = fi_reg;
    assign response.ok           = rok_reg;
    assign response.count        = rc_reg;
    assign response.empty_res    = re_reg;
endmodule

FILE: verif/tb_bounded_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_list_engine
// Drives list requests through the request channel and checks every response
// word against a behavioral list kept in the bench, across idle/stall phases.
// ----------------------------------------------------------------------------
module tb_bounded_list_engine;
    import ble_pkg::*;

    localparam int CAP       = 64;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1600;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [6:0]  pos;
        logic signed [31:0] word;
    } list_req_t;

    typedef struct packed {
        logic signed [31:0] rd_word;
        logic signed [6:0]  idx;
        logic               ok;
        logic [6:0]         cnt;
        logic               empty;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    ble_req_if req_ch();
    ble_rsp_if rsp_ch();

    bounded_list_engine #(.CAPACITY(CAP), .WORD_WIDTH(32)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_ch.sink),
        .response (rsp_ch.source)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // behavioral list and expected responses
    logic signed [31:0] list_words [CAP];
    int                 list_len;
    list_rsp_t          rsp_expected [$];
    list_req_t          req_pending [$];

    int  err_count;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_send;
    bit  stim_done;
    int  quiet_cycles;
    bit  req_fire;

    // compute the response of one request and update the list
    function automatic list_rsp_t apply_list_req(list_req_t r);
        list_rsp_t o;
        int p;
        int k;
        logic signed [31:0] t;
        o = '0;
        o.idx = -7'sd1;
        p = r.pos;
        case (r.kind)
            REQ_APPEND:
            begin
                if (list_len < CAP)
                begin
                    list_words[list_len] = r.word;
                    list_len++;
                    o.ok = 1'b1;
                end
            end
            REQ_FIND, REQ_REM_VAL:
            begin
                k = -1;
                for (int i = 0; i < list_len; i++)
                begin
                    if (k < 0 && list_words[i] == r.word)
                        k = i;
                end
                if (k >= 0)
                begin
                    o.ok = 1'b1;
                    if (r.kind == REQ_FIND)
                        o.idx = k[6:0];
                    else
                    begin
                        o.rd_word = list_words[k];
                        for (int i = k; i < list_len - 1; i++)
                            list_words[i] = list_words[i + 1];
                        list_len--;
                    end
                end
            end
            REQ_REM_AT:
            begin
                if (p >= 0 && p < list_len)
                begin
                    o.rd_word = list_words[p];
                    for (int i = p; i < list_len - 1; i++)
                        list_words[i] = list_words[i + 1];
                    list_len--;
                    o.ok = 1'b1;
                end
            end
            REQ_GET:
            begin
                if (p < 0)
                    p += list_len;
                if (p >= 0 && p < list_len)
                begin
                    o.rd_word = list_words[p];
                    o.ok = 1'b1;
                end
            end
            REQ_INSERT:
            begin
                if (p < 0)
                    p += list_len;
                if (p >= 0 && p < list_len && list_len < CAP)
                begin
                    for (int i = list_len; i > p; i--)
                        list_words[i] = list_words[i - 1];
                    list_words[p] = r.word;
                    list_len++;
                    o.ok = 1'b1;
                end
            end
            REQ_REVERSE:
            begin
                for (int i = 0; i < list_len / 2; i++)
                begin
                    t = list_words[i];
                    list_words[i] = list_words[list_len - 1 - i];
                    list_words[list_len - 1 - i] = t;
                end
                o.ok = 1'b1;
            end
            default:
            begin
                list_len = 0;
                o.ok = 1'b1;
            end
        endcase
        o.cnt = list_len[6:0];
        o.empty = (list_len == 0);
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // pick a word, often one already held so find/remove hit
    function automatic logic signed [31:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5 && list_len > 0)
            return list_words[$urandom_range(0, list_len - 1)];
        else if (sel < 7)
            return $signed($urandom_range(0, 7)) - 32'sd4;
        else
            return $urandom;
    endfunction

    // queue a request for the driver
    task automatic add_req(logic [2:0] kind, logic signed [6:0] pos, logic signed [31:0] word);
        list_req_t r;
        r.kind = kind;
        r.pos  = pos;
        r.word = word;
        req_pending.push_back(r);
    endtask

    // driver: presents words on the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (!req_ch.valid || req_fire)
            begin
                // previous word accepted at the last rising edge (or none held)
                if (req_pending.size() > 0 && !hold_send &&
                    $urandom_range(0, 99) >= send_idle_pct)
                begin
                    list_req_t r;
                    r = req_pending.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= r.kind;
                    req_ch.position <= r.pos;
                    req_ch.value    <= r.word;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: samples accepted words on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (req_ch.valid && req_ch.ready)
            begin
                list_req_t r;
                r.kind = req_ch.req_type;
                r.pos  = req_ch.position;
                r.word = req_ch.value;
                rsp_expected.push_back(apply_list_req(r));
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (rsp_expected.size() == 0)
                begin
                    $display("MISMATCH unexpected response word at %0t", $realtime);
                    err_count++;
                end
                else
                begin
                    list_rsp_t e;
                    e = rsp_expected.pop_front();
                    if (rsp_ch.result_value !== e.rd_word)
                        report_mismatch("result_value", rsp_ch.result_value, e.rd_word);
                    if (rsp_ch.found_index !== e.idx)
                        report_mismatch("found_index", rsp_ch.found_index, e.idx);
                    if (rsp_ch.ok !== e.ok)
                        report_mismatch("ok", rsp_ch.ok, e.ok);
                    if (rsp_ch.count !== e.cnt)
                        report_mismatch("count", rsp_ch.count, e.cnt);
                    if (rsp_ch.empty_res !== e.empty)
                        report_mismatch("empty_res", rsp_ch.empty_res, e.empty);
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if (quiet_cycles >= WDOG_MAX)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // random request with a rough model of the list length for good positions
    int est_len;

    task automatic add_random_req();
        logic [2:0] kind;
        int sel;
        logic signed [6:0] pos;
        sel = $urandom_range(0, 99);
        // keep lists mostly non-trivial; clear rarely
        if (sel < 28)       kind = REQ_APPEND;
        else if (sel < 38)  kind = REQ_FIND;
        else if (sel < 48)  kind = REQ_REM_VAL;
        else if (sel < 58)  kind = REQ_REM_AT;
        else if (sel < 72)  kind = REQ_GET;
        else if (sel < 90)  kind = REQ_INSERT;
        else if (sel < 97)  kind = REQ_REVERSE;
        else                kind = REQ_CLEAR;
        if ($urandom_range(0, 3) == 0)
            pos = 7'($urandom);
        else if ($urandom_range(0, 1) == 0)
            pos = 7'($urandom_range(0, est_len > 0 ? est_len : 0));
        else
            pos = 7'(-$signed({25'd0, 7'($urandom_range(1, est_len > 0 ? est_len : 1))}));
        case (kind)
            REQ_APPEND, REQ_INSERT: if (est_len < CAP) est_len++;
            REQ_REM_VAL, REQ_REM_AT: if (est_len > 0 && sel[0]) est_len--;
            REQ_CLEAR: est_len = 0;
            default: ;
        endcase
        // word: small values repeat so find/remove often hit
        add_req(kind, pos, $urandom_range(0, 2) == 0 ? $urandom :
                $signed($urandom_range(0, 15)) - 32'sd8);
    endtask

    task automatic wait_drained();
        while (req_pending.size() > 0 || req_ch.valid || rsp_expected.size() > 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_APPEND;
        req_ch.position = '0;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        rst_n           = 1'b0;
        err_count       = 0;
        quiet_cycles    = 0;
        list_len        = 0;
        est_len         = 0;
        hold_send       = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-list cases, extremes, every request
        add_req(REQ_GET, -7'sd1, 32'sd0);
        add_req(REQ_REVERSE, 7'sd0, 32'sd0);
        add_req(REQ_INSERT, 7'sd0, 32'sd5);
        add_req(REQ_APPEND, 7'sd0, 32'h7fffffff);
        add_req(REQ_REVERSE, 7'sd0, 32'sd0);
        add_req(REQ_APPEND, 7'sd63, 32'h80000000);
        add_req(REQ_APPEND, -7'sd64, 32'hffffffff);
        add_req(REQ_INSERT, -7'sd1, 32'sd42);
        add_req(REQ_INSERT, 7'sd4, 32'sd9);
        add_req(REQ_INSERT, -7'sd5, 32'sd9);
        add_req(REQ_FIND, 7'sd0, 32'h80000000);
        add_req(REQ_FIND, 7'sd0, 32'sd1234);
        add_req(REQ_GET, -7'sd64, 32'sd0);
        add_req(REQ_GET, 7'sd63, 32'sd0);
        add_req(REQ_GET, -7'sd4, 32'sd0);
        add_req(REQ_REVERSE, 7'sd0, 32'sd0);
        add_req(REQ_REM_AT, -7'sd1, 32'sd0);
        add_req(REQ_REM_AT, 7'sd3, 32'sd0);
        add_req(REQ_REM_VAL, 7'sd0, 32'sd777);
        add_req(REQ_REM_VAL, 7'sd0, 32'h7fffffff);
        add_req(REQ_REM_AT, 7'sd0, 32'sd0);
        add_req(REQ_CLEAR, 7'sd0, 32'sd0);
        add_req(REQ_REM_AT, 7'sd0, 32'sd0);
        wait_drained();

        // fill to capacity, then full-list refusals, reads, a reverse and a clear
        for (int i = 0; i < CAP; i++)
            add_req(REQ_APPEND, 7'sd0, $urandom);
        add_req(REQ_APPEND, 7'sd0, 32'sd1);
        add_req(REQ_INSERT, 7'sd0, 32'sd1);
        add_req(REQ_GET, 7'sd63, 32'sd0);
        add_req(REQ_REVERSE, 7'sd0, 32'sd0);
        add_req(REQ_GET, -7'sd64, 32'sd0);
        add_req(REQ_CLEAR, 7'sd0, 32'sd0);
        est_len = 0;

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            send_idle_pct  = (ph == 1) ? 45 : (ph == 3) ? 14 : 0;
            recv_stall_pct = (ph == 2) ? 45 : (ph == 3) ? 14 : 0;
            for (int i = 0; i < N_RANDOM / 4; i++)
            begin
                add_random_req();
                // pause until everything is answered, once mid-phase
                if (ph == 1 && i == 100)
                begin
                    wait_drained();
                    hold_send = 1'b1;
                    repeat (CAP + 4) @(posedge clk);
                    hold_send = 1'b0;
                end
            end
        end
        wait_drained();
        repeat (CAP * 2 + 10) @(posedge clk);

        if (err_count == 0 && rsp_expected.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

FILE: bounded_list_engine.f
rtl/core/ble_pkg.sv
rtl/core/ble_req_if.sv
rtl/core/ble_rsp_if.sv
rtl/core/ble_cell.sv
rtl/core/bounded_list_engine.sv
verif/tb_bounded_list_engine.sv
